>>> rtl/core/hdbva_pkg.sv
// package for the doppler bit vote accumulator: sizes, codes, command and
// status structs, and helpers used to build the trig tables at elaboration
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hdbva_pkg;

    localparam int DEF_THETA_BINS   = 180;
    localparam int DEF_RHO_BINS     = 128;
    localparam int DEF_DOPPLER_BITS = 64;
    localparam int DEF_BATCHES      = 4;

    // dividend width of the shared divider, covers the mask level and the rho bin
    localparam int DIV_W = 24;

    localparam logic [14:0] RST_MAX_SPEED  = 15'd8000;
    localparam logic [15:0] RST_RHO_STEP   = 16'd64;
    localparam logic [15:0] RST_RHO_OFFSET = 16'd4096;

    localparam logic [1:0] REG_MAX_SPEED  = 2'd0;
    localparam logic [1:0] REG_RHO_STEP   = 2'd1;
    localparam logic [1:0] REG_RHO_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        OP_VOTE  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef struct packed {
        logic load;
        logic mask_start;
        logic mask_build;
        logic reduce;
        logic mul0;
        logic mul1;
        logic sum;
        logic rho_start;
        logic addr_load;
        logic mem_wr;
        logic advance;
        logic q_init;
        logic q_acc;
        logic out_load;
        logic clr_init;
        logic clr_step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic k_big;
        logic range_end;
        logic vote_null;
        logic num_neg;
        logic bin_oob;
        logic q_oob;
        logic q_last;
        logic out_busy;
        logic clr_last;
    } t_dp_stat;

    function automatic logic [63:0] hprod(input logic [63:0] x2, input logic [63:0] inner);
        hprod = (x2 * inner) >> 30;
    endfunction

    function automatic logic [63:0] hsub(input logic [63:0] sub);
        hsub = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
    endfunction

    function automatic logic [15:0] to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd16384) >> 15;
        to_q15 = (r > 64'd32767) ? 16'd32767 : r[15:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/hough_doppler_bit_vote_accumulator_top.sv
// Hough accumulator with a doppler bit mask per batch in every cell.
// Requests come in on the s_axis channel: tuser holds the operation
// (vote, query, clear), tdata the remaining fields. Only a query gives a
// result, on m_axis, holding the AND of the cell's batch masks.
// Registers max_speed, rho_step, rho_offset sit on the APB port at 0x0,
// 0x4, 0x8; write them only while the block is idle.
// One request is worked at a time. A vote first builds its mask with the
// bit-serial divider, then for every angle in its range finds the rho
// bin with the same divider and does a read-modify-write of the store.
// A query ANDs the BATCHES masks of its cell (zero for a cell out of
// range); a clear sweeps all THETA_BINS*RHO_BINS*BATCHES words of the
// store (92160 by default). After reset the same clearing pass runs
// before the first request is taken; config writes are accepted throughout.
// A query result sits in an output register; a stalled receiver holds it
// there, and the next query's result waits until it has been taken.
// depends on hdbva_pkg, hdbva_ctrl, hdbva_datapath
`timescale 1ns / 1ps
`default_nettype none

module hough_doppler_bit_vote_accumulator_top
    import hdbva_pkg::*;
#(
    parameter int THETA_BINS   = DEF_THETA_BINS,
    parameter int RHO_BINS     = DEF_RHO_BINS,
    parameter int DOPPLER_BITS = DEF_DOPPLER_BITS,
    parameter int BATCHES      = DEF_BATCHES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // batch[1:0] theta_first[10:2] theta_stop[19:11] offset_x[35:20]
    // offset_y[51:36] radial_speed[67:52] tolerance_bits[73:68]
    // query_theta[81:74] query_rho[88:82], zero above
    input  wire logic [95:0] s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // common_mask[63:0] any_common[64] cell_theta[72:65] cell_rho[79:73]
    output logic [79:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic [63:0] common_mask;
    logic        any_common;
    logic [7:0]  cell_theta;
    logic [6:0]  cell_rho;

    assign pready = 1'b1;

    hdbva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hdbva_datapath #(
        .THETA_BINS   (THETA_BINS),
        .RHO_BINS     (RHO_BINS),
        .DOPPLER_BITS (DOPPLER_BITS),
        .BATCHES      (BATCHES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_batch          (s_axis_tdata[1:0]),
        .i_theta_first    (s_axis_tdata[10:2]),
        .i_theta_stop     (s_axis_tdata[19:11]),
        .i_offset_x       (s_axis_tdata[35:20]),
        .i_offset_y       (s_axis_tdata[51:36]),
        .i_radial_speed   (s_axis_tdata[67:52]),
        .i_tolerance_bits (s_axis_tdata[73:68]),
        .i_query_theta    (s_axis_tdata[81:74]),
        .i_query_rho      (s_axis_tdata[88:82]),
        .i_cfg_we         (psel & penable & pwrite),
        .i_cfg_idx        (paddr[3:2]),
        .i_cfg_wdata      (pwdata),
        .o_cfg_rdata      (prdata),
        .i_m_ready        (m_axis_tready),
        .o_m_valid        (m_axis_tvalid),
        .o_common_mask    (common_mask),
        .o_any_common     (any_common),
        .o_cell_theta     (cell_theta),
        .o_cell_rho       (cell_rho)
    );

    assign m_axis_tdata = {cell_rho, cell_theta, any_common, common_mask};

endmodule

`default_nettype wire

>>> rtl/core/hdbva_divider.sv
// iterative restoring divider, one quotient bit a cycle
// depends on hdbva_pkg
`timescale 1ns / 1ps
`default_nettype none

module hdbva_divider
    import hdbva_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [15:0]      i_divisor,
    output logic [DIV_W-1:0]      o_quotient,
    output logic                  o_done
);
    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_rem;
    logic [15:0]      r_div;
    logic [DIV_W-1:0] r_quo;
    logic [16:0]      trial;
    logic             fits;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? 16'(trial - {1'b0, r_div}) : trial[15:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

>>> rtl/core/hdbva_datapath.sv
// datapath: config registers, trig tables, mask build, projection,
// vote store memory, query accumulate and output register
// depends on hdbva_pkg and hdbva_divider
`timescale 1ns / 1ps
`default_nettype none

module hdbva_datapath
    import hdbva_pkg::*;
#(
    parameter int THETA_BINS   = DEF_THETA_BINS,
    parameter int RHO_BINS     = DEF_RHO_BINS,
    parameter int DOPPLER_BITS = DEF_DOPPLER_BITS,
    parameter int BATCHES      = DEF_BATCHES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_stat         o_stat,
    input  wire logic [1:0]  i_batch,
    input  wire logic [8:0]  i_theta_first,
    input  wire logic [8:0]  i_theta_stop,
    input  wire logic [15:0] i_offset_x,
    input  wire logic [15:0] i_offset_y,
    input  wire logic [15:0] i_radial_speed,
    input  wire logic [5:0]  i_tolerance_bits,
    input  wire logic [7:0]  i_query_theta,
    input  wire logic [6:0]  i_query_rho,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    output logic [31:0]      o_cfg_rdata,
    input  wire logic        i_m_ready,
    output logic             o_m_valid,
    output logic [63:0]      o_common_mask,
    output logic             o_any_common,
    output logic [7:0]       o_cell_theta,
    output logic [6:0]       o_cell_rho
);
    localparam int TI_W  = (THETA_BINS > 1) ? $clog2(THETA_BINS) : 1;
    localparam int KB_W  = $clog2(2 * THETA_BINS + 1);
    localparam int R_W   = (KB_W > 9) ? KB_W : 9;
    localparam int RB_W  = $clog2(RHO_BINS);
    localparam int BT_W  = $clog2(BATCHES);
    localparam int WORDS = THETA_BINS * RHO_BINS * BATCHES;
    localparam int A_W   = $clog2(WORDS);
    localparam int HALF  = DOPPLER_BITS / 2;
    localparam int DB    = DOPPLER_BITS;

    // config
    logic [14:0] r_max_speed;
    logic [15:0] r_rho_step;
    logic [15:0] r_rho_offset;
    logic [14:0] m_eff;
    logic [15:0] step_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed  <= RST_MAX_SPEED;
            r_rho_step   <= RST_RHO_STEP;
            r_rho_offset <= RST_RHO_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_SPEED:  r_max_speed  <= i_cfg_wdata[14:0];
                REG_RHO_STEP:   r_rho_step   <= i_cfg_wdata[15:0];
                REG_RHO_OFFSET: r_rho_offset <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cfg_idx)
            REG_MAX_SPEED:  o_cfg_rdata = {17'd0, r_max_speed};
            REG_RHO_STEP:   o_cfg_rdata = {16'd0, r_rho_step};
            REG_RHO_OFFSET: o_cfg_rdata = {16'd0, r_rho_offset};
            default:        o_cfg_rdata = '0;
        endcase
    end

    assign m_eff    = (r_max_speed == '0) ? 15'd1 : r_max_speed;
    assign step_eff = (r_rho_step == '0) ? 16'd1 : r_rho_step;

    // trig tables, Q1.15, built at elaboration
    logic signed [16:0] cos_tab [THETA_BINS];
    logic signed [16:0] sin_tab [THETA_BINS];

    for (genvar g = 0; g < THETA_BINS; g++) begin : g_trig
        localparam bit          NEG = (2 * g > THETA_BINS);
        localparam logic [63:0] J   = NEG ? 64'(THETA_BINS - g) : 64'(g);
        localparam logic [63:0] X   = (J * PI_Q30) / THETA_BINS;
        localparam logic [63:0] X2  = (X * X) >> 30;
        localparam logic [63:0] C1  = hsub(hprod(X2, Q30_ONE) / 132);
        localparam logic [63:0] C2  = hsub(hprod(X2, C1) / 90);
        localparam logic [63:0] C3  = hsub(hprod(X2, C2) / 56);
        localparam logic [63:0] C4  = hsub(hprod(X2, C3) / 30);
        localparam logic [63:0] C5  = hsub(hprod(X2, C4) / 12);
        localparam logic [63:0] C6  = hsub(hprod(X2, C5) / 2);
        localparam logic [63:0] S1  = hsub(hprod(X2, Q30_ONE) / 110);
        localparam logic [63:0] S2  = hsub(hprod(X2, S1) / 72);
        localparam logic [63:0] S3  = hsub(hprod(X2, S2) / 42);
        localparam logic [63:0] S4  = hsub(hprod(X2, S3) / 20);
        localparam logic [63:0] S5  = hsub(hprod(X2, S4) / 6);
        localparam logic [63:0] SV  = (X * S5) >> 30;
        localparam logic signed [16:0] CQ = $signed({1'b0, to_q15(C6)});
        localparam logic signed [16:0] SQ = $signed({1'b0, to_q15(SV)});
        assign cos_tab[g] = NEG ? -CQ : CQ;
        assign sin_tab[g] = SQ;
    end

    // item registers
    logic [1:0]         r_batch;
    logic [8:0]         r_stop;
    logic [8:0]         r_i;
    logic [R_W-1:0]     r_k;
    logic signed [15:0] r_px;
    logic signed [15:0] r_py;
    logic [15:0]        r_speed;
    logic [5:0]         r_tol;
    logic [7:0]         r_qt;
    logic [6:0]         r_qr;
    logic [DB-1:0]      r_mask;
    logic signed [32:0] r_prod0;
    logic signed [32:0] r_prod1;
    logic signed [34:0] r_num;
    logic [A_W-1:0]     r_addr;
    logic [A_W-1:0]     r_clr_addr;
    logic [BT_W-1:0]    r_qb;
    logic [DB-1:0]      r_acc;
    logic [DB-1:0]      r_rdata;

    // divider
    logic [DIV_W-1:0] div_dividend;
    logic [15:0]      div_divisor;
    logic [DIV_W-1:0] quo;
    logic             div_done;

    // mask level numerator
    logic [15:0] abs_speed;
    logic [14:0] a_sp;
    logic [14:0] diff;

    assign abs_speed = r_speed[15] ? 16'(-r_speed) : r_speed;
    assign a_sp      = (abs_speed > {1'b0, m_eff}) ? m_eff : abs_speed[14:0];
    assign diff      = m_eff - a_sp;

    assign div_dividend = i_cmd.mask_start ? DIV_W'(DIV_W'(diff) * DIV_W'(HALF))
                                           : DIV_W'(r_num[33:15]);
    assign div_divisor  = i_cmd.mask_start ? {1'b0, m_eff} : step_eff;

    hdbva_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mask_start | i_cmd.rho_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    // mask from the level
    logic [7:0]    level;
    logic [7:0]    centre;
    logic [7:0]    lo;
    logic [7:0]    hi_raw;
    logic [7:0]    hi;
    logic [DB-1:0] mask_new;

    always_comb begin
        level  = (quo > DIV_W'(HALF - 1)) ? 8'(HALF - 1) : quo[7:0];
        centre = r_speed[15] ? level : 8'(2 * HALF - 1) - level;
        lo     = (centre > {2'b0, r_tol}) ? centre - {2'b0, r_tol} : 8'd0;
        hi_raw = centre + {2'b0, r_tol};
        hi     = (hi_raw > 8'(DB - 1)) ? 8'(DB - 1) : hi_raw;
        for (int b = 0; b < DB; b++) begin
            mask_new[b] = (8'(b) >= lo) && (8'(b) <= hi);
        end
    end

    // angle selection, upper half uses negated entries
    logic               k_neg;
    logic [TI_W-1:0]    idx;
    logic signed [16:0] c_sel;
    logic signed [16:0] s_sel;

    assign k_neg = r_k >= R_W'(THETA_BINS);
    assign idx   = k_neg ? TI_W'(r_k - R_W'(THETA_BINS)) : TI_W'(r_k);
    assign c_sel = k_neg ? -cos_tab[idx] : cos_tab[idx];
    assign s_sel = k_neg ? -sin_tab[idx] : sin_tab[idx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_batch <= i_batch;
            r_stop  <= i_theta_stop;
            r_i     <= i_theta_first;
            r_k     <= R_W'(i_theta_first);
            r_px    <= $signed(i_offset_x);
            r_py    <= $signed(i_offset_y);
            r_speed <= i_radial_speed;
            r_tol   <= i_tolerance_bits;
            r_qt    <= i_query_theta;
            r_qr    <= i_query_rho;
        end
        if (i_cmd.mask_build) begin
            r_mask <= mask_new;
        end
        if (i_cmd.reduce) begin
            r_k <= r_k - R_W'(2 * THETA_BINS);
        end
        if (i_cmd.mul0) begin
            r_prod0 <= 33'(r_px) * 33'(c_sel);
        end
        if (i_cmd.mul1) begin
            r_prod1 <= 33'(r_py) * 33'(s_sel);
        end
        if (i_cmd.sum) begin
            r_num <= 35'(r_prod0) + 35'(r_prod1) + $signed({4'd0, r_rho_offset, 15'd0});
        end
        if (i_cmd.addr_load) begin
            r_addr <= A_W'((A_W'(idx) * A_W'(RHO_BINS) + A_W'(quo[RB_W-1:0]))
                           * A_W'(BATCHES) + A_W'(r_batch));
        end
        if (i_cmd.advance) begin
            r_i <= r_i + 9'd1;
            r_k <= (r_k == R_W'(2 * THETA_BINS - 1)) ? '0 : r_k + 1'b1;
        end
        if (i_cmd.q_init) begin
            r_addr <= A_W'((A_W'(r_qt) * A_W'(RHO_BINS) + A_W'(r_qr)) * A_W'(BATCHES));
            r_acc  <= o_stat.q_oob ? '0 : '1;
            r_qb   <= '0;
        end
        if (i_cmd.q_acc) begin
            r_acc  <= r_acc & r_rdata;
            r_addr <= r_addr + 1'b1;
            r_qb   <= r_qb + 1'b1;
        end
    end

    // clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_init) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // vote store
    logic [DB-1:0] mem [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.mem_wr) begin
            mem[r_addr] <= r_rdata | r_mask;
        end
        r_rdata <= mem[r_addr];
    end

    // result register
    logic          r_out_valid;
    logic [DB-1:0] r_out_mask;
    logic [7:0]    r_out_theta;
    logic [6:0]    r_out_rho;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_mask  <= r_acc;
            r_out_theta <= r_qt;
            r_out_rho   <= r_qr;
        end
    end

    assign o_m_valid     = r_out_valid;
    assign o_common_mask = 64'(r_out_mask);
    assign o_any_common  = r_out_mask != '0;
    assign o_cell_theta  = r_out_theta;
    assign o_cell_rho    = r_out_rho;

    always_comb begin
        o_stat.div_done  = div_done;
        o_stat.k_big     = r_k >= R_W'(2 * THETA_BINS);
        o_stat.range_end = r_i >= r_stop;
        o_stat.vote_null = (r_speed == '0) || (32'(r_batch) >= BATCHES);
        o_stat.num_neg   = r_num[34];
        o_stat.bin_oob   = quo >= DIV_W'(RHO_BINS);
        o_stat.q_oob     = (32'(r_qt) >= THETA_BINS) || (32'(r_qr) >= RHO_BINS);
        o_stat.q_last    = r_qb == BT_W'(BATCHES - 1);
        o_stat.out_busy  = r_out_valid && !i_m_ready;
        o_stat.clr_last  = r_clr_addr == A_W'(WORDS - 1);
    end

endmodule

`default_nettype wire

>>> rtl/core/hdbva_ctrl.sv
// controller state machine: sequences vote, query and clear requests
// depends on hdbva_pkg
`timescale 1ns / 1ps
`default_nettype none

module hdbva_ctrl
    import hdbva_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_op,
    output logic            o_in_ready,
    input  wire t_dp_stat   i_stat,
    output t_dp_cmd         o_cmd
);
    typedef enum logic [18:0] {
        S_CLEAR  = 19'b0000000000000000001,
        S_IDLE   = 19'b0000000000000000010,
        S_MSTART = 19'b0000000000000000100,
        S_MWAIT  = 19'b0000000000000001000,
        S_MBUILD = 19'b0000000000000010000,
        S_REDUCE = 19'b0000000000000100000,
        S_CHECK  = 19'b0000000000001000000,
        S_MUL0   = 19'b0000000000010000000,
        S_MUL1   = 19'b0000000000100000000,
        S_SUM    = 19'b0000000001000000000,
        S_RSTART = 19'b0000000010000000000,
        S_RWAIT  = 19'b0000000100000000000,
        S_ADDR   = 19'b0000001000000000000,
        S_RD     = 19'b0000010000000000000,
        S_WR     = 19'b0000100000000000000,
        S_NEXT   = 19'b0001000000000000000,
        S_QINIT  = 19'b0010000000000000000,
        S_QRD    = 19'b0100000000000000000,
        S_QACC   = 19'b1000000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   out_wait;
    logic   r_out_pend;
    logic   n_out_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_out_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_pend <= n_out_pend;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_out_pend;
    assign out_wait   = i_stat.out_busy;

    always_comb begin
        n_state    = r_state;
        n_out_pend = r_out_pend;
        o_cmd      = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // a finished query waits here until the result register is free
                if (r_out_pend) begin
                    if (!out_wait) begin
                        o_cmd.out_load = 1'b1;
                        n_out_pend     = 1'b0;
                    end
                end else if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (t_op'(i_op))
                        OP_VOTE:  n_state = S_MSTART;
                        OP_QUERY: n_state = S_QINIT;
                        OP_CLEAR: begin
                            o_cmd.clr_init = 1'b1;
                            n_state        = S_CLEAR;
                        end
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_MSTART: begin
                if (i_stat.vote_null) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.mask_start = 1'b1;
                    n_state          = S_MWAIT;
                end
            end
            S_MWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_MBUILD;
                end
            end
            S_MBUILD: begin
                o_cmd.mask_build = 1'b1;
                n_state          = S_REDUCE;
            end
            S_REDUCE: begin
                if (i_stat.k_big) begin
                    o_cmd.reduce = 1'b1;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.range_end ? S_IDLE : S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_RSTART;
            end
            S_RSTART: begin
                if (i_stat.num_neg) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.rho_start = 1'b1;
                    n_state         = S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                if (i_stat.bin_oob) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.addr_load = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.advance = 1'b1;
                n_state       = S_CHECK;
            end
            S_QINIT: begin
                o_cmd.q_init = 1'b1;
                if (i_stat.q_oob) begin
                    n_out_pend = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_QRD: begin
                n_state = S_QACC;
            end
            S_QACC: begin
                o_cmd.q_acc = 1'b1;
                if (i_stat.q_last) begin
                    n_out_pend = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_QRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire
